@@ src/flr_pkg.sv @@
// Shared constants for the fixed-point line rasterizer.
package flr_pkg;

  localparam int COLOUR_BITS = 4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

endpackage

@@ src/flr_cmd_if.sv @@
// Command channel: start or step items into the rasterizer.
interface flr_cmd_if import flr_pkg::*; #(
  parameter int COORD_BITS = 11
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOUR_BITS-1:0]       colour;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, colour, input ready);
  modport sink (input valid, cmd, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

@@ src/flr_pix_if.sv @@
// Pixel channel: rasterized points out of the rasterizer.
interface flr_pix_if import flr_pkg::*; #(
  parameter int COORD_BITS = 11
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [COLOUR_BITS-1:0]     pixel_colour;
  logic                       last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_colour, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_colour, last_pixel, output ready);
endinterface

@@ src/fixed_point_line_rasterizer.sv @@
// Line rasterizer: start item sets up a line through a serial divider, steps emit pixels.
// Start transfer: cmd ready drops for setup (select/scale, then one quotient bit per cycle).
// Step transfer: pixel is in the output register the next cycle; steps sustain one per cycle
// while the pixel receiver holds ready.
// The next step can transfer in the same cycle the previous pixel leaves the output register.
// Reset (rst, synchronous): idle, no line, output register empty.
module fixed_point_line_rasterizer import flr_pkg::*; #(
  parameter int FRACTION_SCALE = 256,
  parameter int COORD_BITS     = 11
) (
  input logic       clk,
  input logic       rst,
  flr_cmd_if.sink   cmd_ch,
  flr_pix_if.source pix_ch
);

  localparam int SB = $clog2(FRACTION_SCALE + 1);
  localparam int FB = $clog2(FRACTION_SCALE);
  localparam int NW = COORD_BITS + SB;
  localparam int CW = $clog2(NW);
  localparam int OB = COORD_BITS + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DRAW = 2'd3;

  logic [1:0]              state;
  logic                    out_valid;
  logic [COORD_BITS-1:0]   origin_x, origin_y, final_x, final_y;
  logic [COLOUR_BITS-1:0]  held_colour;
  logic [COORD_BITS-1:0]   abs_dx, abs_dy;
  logic                    neg_dx, neg_dy;
  logic                    steep_flag, step_sign, minor_neg;
  logic [COORD_BITS-1:0]   major_index, major_limit, minor_int;
  logic [FB-1:0]           minor_frac;
  logic [COORD_BITS-1:0]   rem;
  logic [NW-1:0]           quot;
  logic [CW-1:0]           cnt;
  logic [OB-1:0]           out_x, out_y;
  logic [COLOUR_BITS-1:0]  out_colour;
  logic                    out_last;

  logic                    out_free, in_fire, start_fire, step_emit, at_end;
  logic [OB-1:0]           dx, dy, dx_mag, dy_mag;
  logic                    steep;
  logic [COORD_BITS-1:0]   minor_mag;
  logic [NW-1:0]           num_init;
  logic [COORD_BITS:0]     trial, diff;
  logic                    fits;
  logic [SB:0]             frac_sum;
  logic                    carry;
  logic [COORD_BITS-1:0]   maj_org, min_org;
  logic [OB-1:0]           maj_off, min_off, maj_pos, min_pos;

  assign out_free   = !out_valid || pix_ch.ready;
  assign cmd_ch.ready = (state inside {ST_IDLE, ST_DRAW}) && out_free;
  assign in_fire    = cmd_ch.valid && cmd_ch.ready;
  assign start_fire = in_fire && (cmd_ch.cmd == CMD_START);
  assign step_emit  = in_fire && (cmd_ch.cmd == CMD_STEP) && (state == ST_DRAW);
  assign at_end     = major_index == major_limit;

  // setup: deltas and magnitudes
  assign dx     = {cmd_ch.end_x[COORD_BITS-1], cmd_ch.end_x}
                - {cmd_ch.start_x[COORD_BITS-1], cmd_ch.start_x};
  assign dy     = {cmd_ch.end_y[COORD_BITS-1], cmd_ch.end_y}
                - {cmd_ch.start_y[COORD_BITS-1], cmd_ch.start_y};
  assign dx_mag = dx[OB-1] ? (~dx + OB'(1)) : dx;
  assign dy_mag = dy[OB-1] ? (~dy + OB'(1)) : dy;

  // axis select and scaled minor delta
  assign steep     = abs_dy > abs_dx;
  assign minor_mag = steep ? abs_dx : abs_dy;
  assign num_init  = NW'(minor_mag) * NW'(FRACTION_SCALE);

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, quot[NW-1]};
  assign fits  = trial >= {1'b0, major_limit};
  assign diff  = trial - {1'b0, major_limit};

  // minor accumulator as integer plus fraction; step magnitude never exceeds the scale
  assign frac_sum = (SB + 1)'(minor_frac) + (SB + 1)'(quot[SB-1:0]);
  assign carry    = frac_sum >= (SB + 1)'(FRACTION_SCALE);

  assign maj_org = steep_flag ? origin_y : origin_x;
  assign min_org = steep_flag ? origin_x : origin_y;
  assign maj_off = step_sign ? (~{1'b0, major_index} + OB'(1)) : {1'b0, major_index};
  assign min_off = minor_neg ? (~{1'b0, minor_int} + OB'(1)) : {1'b0, minor_int};
  assign maj_pos = {maj_org[COORD_BITS-1], maj_org} + maj_off;
  assign min_pos = {min_org[COORD_BITS-1], min_org} + min_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (step_emit) begin
        out_valid <= 1'b1;
      end else if (pix_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE, ST_DRAW: begin
          if (start_fire) begin
            state <= ST_PREP;
          end else if (step_emit && at_end) begin
            state <= ST_IDLE;
          end
        end
        ST_PREP: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DRAW;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      origin_x    <= cmd_ch.start_x;
      origin_y    <= cmd_ch.start_y;
      final_x     <= cmd_ch.end_x;
      final_y     <= cmd_ch.end_y;
      held_colour <= cmd_ch.colour;
      abs_dx      <= dx_mag[COORD_BITS-1:0];
      abs_dy      <= dy_mag[COORD_BITS-1:0];
      neg_dx      <= dx[OB-1];
      neg_dy      <= dy[OB-1];
    end
    if (state == ST_PREP) begin
      steep_flag  <= steep;
      step_sign   <= steep ? neg_dy : neg_dx;
      minor_neg   <= steep ? neg_dx : neg_dy;
      major_limit <= steep ? abs_dy : abs_dx;
      quot        <= num_init;
      rem         <= '0;
      cnt         <= CW'(NW - 1);
      major_index <= '0;
      minor_int   <= '0;
      minor_frac  <= '0;
    end
    if (state == ST_DIV) begin
      rem  <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quot <= {quot[NW-2:0], fits};
      cnt  <= cnt - CW'(1);
    end
    if (step_emit) begin
      out_colour <= held_colour;
      if (at_end) begin
        out_x    <= {final_x[COORD_BITS-1], final_x};
        out_y    <= {final_y[COORD_BITS-1], final_y};
        out_last <= 1'b1;
      end else begin
        out_x       <= steep_flag ? min_pos : maj_pos;
        out_y       <= steep_flag ? maj_pos : min_pos;
        out_last    <= 1'b0;
        major_index <= major_index + COORD_BITS'(1);
        minor_frac  <= carry ? FB'(frac_sum - (SB + 1)'(FRACTION_SCALE)) : FB'(frac_sum);
        if (carry) begin
          minor_int <= minor_int + COORD_BITS'(1);
        end
      end
    end
  end

  assign pix_ch.valid        = out_valid;
  assign pix_ch.pixel_x      = out_x;
  assign pix_ch.pixel_y      = out_y;
  assign pix_ch.pixel_colour = out_colour;
  assign pix_ch.last_pixel   = out_last;

endmodule

@@ src/flr_checker.sv @@
// Port-level checks for the line rasterizer, bound to the top level.
module flr_checker import flr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_valid,
  input logic                   cmd_ready,
  input logic                   cmd,
  input logic                   pix_valid,
  input logic                   pix_ready,
  input logic [COORD_BITS:0]    pixel_x,
  input logic [COORD_BITS:0]    pixel_y,
  input logic [COLOUR_BITS-1:0] pixel_colour,
  input logic                   last_pixel
);

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_colour) && $stable(last_pixel))
    else $error("pixel changed while stalled");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd == CMD_START |=> !cmd_ready)
    else $error("command taken right after start transfer");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd == CMD_START && (!pix_valid || pix_ready) |=> !pix_valid)
    else $error("start transfer produced a pixel");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !pix_valid || pix_ready)
    else $error("command ready with no output room");

endmodule

bind fixed_point_line_rasterizer flr_checker #(.COORD_BITS(COORD_BITS)) u_flr_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd_ch.valid),
  .cmd_ready    (cmd_ch.ready),
  .cmd          (cmd_ch.cmd),
  .pix_valid    (pix_ch.valid),
  .pix_ready    (pix_ch.ready),
  .pixel_x      (pix_ch.pixel_x),
  .pixel_y      (pix_ch.pixel_y),
  .pixel_colour (pix_ch.pixel_colour),
  .last_pixel   (pix_ch.last_pixel)
);

@@ dv/tb_fixed_point_line_rasterizer.sv @@
// Testbench for fixed_point_line_rasterizer: directed plan plus random lines checked by a predictor.
module tb_fixed_point_line_rasterizer;
  import flr_pkg::*;

  localparam int FRACTION_SCALE = 256;
  localparam int COORD_BITS     = 11;
  localparam int RANDOM_ITEMS   = 750;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   pcoord_t;

  typedef struct packed {
    pcoord_t                x;
    pcoord_t                y;
    logic [COLOUR_BITS-1:0] colour;
    logic                   last;
  } pixel_t;

  typedef struct packed {
    logic                   op;
    coord_t                 sx;
    coord_t                 sy;
    coord_t                 ex;
    coord_t                 ey;
    logic [COLOUR_BITS-1:0] col;
    logic                   typed;
    logic                   none;
    pixel_t                 pix;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_ready = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
  flr_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

  assign pix_ch.ready = rx_ready;

  fixed_point_line_rasterizer #(
    .FRACTION_SCALE(FRACTION_SCALE),
    .COORD_BITS    (COORD_BITS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .cmd_ch(cmd_ch),
    .pix_ch(pix_ch)
  );

  // line state mirrored by the predictor
  coord_t                 ln_org_x, ln_org_y, ln_fin_x, ln_fin_y;
  logic [COLOUR_BITS-1:0] ln_colour;
  bit                     ln_steep, ln_neg, ln_busy;
  int                     ln_idx, ln_span, ln_accum, ln_incr;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     pixels_checked = 0;
  int     lines_closed = 0;
  int     items_sent = 0;
  int     starts_sent = 0;
  int     burst_left = 0;
  bit     offered = 1'b0;
  int     idle_run = 0;

  plan_row_t plan[22];

  function automatic bit rasterize_item(input logic op, input coord_t sx, input coord_t sy,
                                        input coord_t ex, input coord_t ey,
                                        input logic [COLOUR_BITS-1:0] col,
                                        output pixel_t pix);
    int dx, dy, major, minor, maj, mnr, px, py;
    pix = '0;
    if (op == CMD_START) begin
      ln_org_x  = sx;
      ln_org_y  = sy;
      ln_fin_x  = ex;
      ln_fin_y  = ey;
      ln_colour = col;
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      ln_steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
      major = ln_steep ? dy : dx;
      minor = ln_steep ? dx : dy;
      ln_neg  = major < 0;
      ln_span = ln_neg ? -major : major;
      ln_incr = (ln_span == 0) ? minor * FRACTION_SCALE : (FRACTION_SCALE * minor) / ln_span;
      ln_idx   = 0;
      ln_accum = 0;
      ln_busy  = 1'b1;
      return 1'b0;
    end
    if (!ln_busy)
      return 1'b0;
    if (ln_idx == ln_span) begin
      px = int'(ln_fin_x);
      py = int'(ln_fin_y);
      pix.last = 1'b1;
      ln_busy  = 1'b0;
    end else begin
      maj = ln_neg ? -ln_idx : ln_idx;
      mnr = ln_accum / FRACTION_SCALE;  // truncates toward zero
      px = int'(ln_org_x) + (ln_steep ? mnr : maj);
      py = int'(ln_org_y) + (ln_steep ? maj : mnr);
      ln_idx++;
      ln_accum += ln_incr;
    end
    pix.x      = px[COORD_BITS:0];
    pix.y      = py[COORD_BITS:0];
    pix.colour = ln_colour;
    return 1'b1;
  endfunction

  task automatic send_item(input logic op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic [COLOUR_BITS-1:0] col,
                           input bit typed = 1'b0, input bit none = 1'b0,
                           input pixel_t want = '0);
    pixel_t pix;
    bit     made;
    int     gap;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.cmd     <= op;
    cmd_ch.start_x <= sx;
    cmd_ch.start_y <= sy;
    cmd_ch.end_x   <= ex;
    cmd_ch.end_y   <= ey;
    cmd_ch.colour  <= col;
    offered = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    made = rasterize_item(op, sx, sy, ex, ey, col, pix);
    if (typed) begin
      made = !none;
      pix  = want;
    end
    if (made)
      pending_pixels.push_back(pix);
    items_sent++;
    if (op == CMD_START)
      starts_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        offered = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    if (offered) begin
      cmd_ch.valid <= 1'b0;
      offered = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // receiver: ready pattern that changes character each time the 6-bit tick wraps
  logic [5:0] rx_tick = '0;
  logic [1:0] rx_mode = '0;
  logic [7:0] rx_pat  = 8'h01;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd0) begin
      rx_mode <= 2'($urandom_range(0, 2));
      rx_pat  <= 8'($urandom) | 8'h01;
    end else begin
      rx_pat <= {rx_pat[0], rx_pat[7:1]};
    end
    case (rx_mode)
      2'd0: rx_ready <= 1'b1;
      2'd1: rx_ready <= ($urandom_range(0, 3) != 0);
      default: rx_ready <= rx_pat[0];
    endcase
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want, got;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      got.x      = pix_ch.pixel_x;
      got.y      = pix_ch.pixel_y;
      got.colour = pix_ch.pixel_colour;
      got.last   = pix_ch.last_pixel;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d last=%0d", $time,
                   got.x, got.y, got.colour, got.last);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (want.last)
          lines_closed++;
        if (got.x !== want.x || got.y !== want.y || got.colour !== want.colour ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel mismatch: expected x=%0d y=%0d colour=%0d last=%0d, got x=%0d y=%0d colour=%0d last=%0d",
                     $time, want.x, want.y, want.colour, want.last,
                     got.x, got.y, got.colour, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_run);
      $display("** fixed_point_line_rasterizer: FAILED **");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int sx, sy, dx, dy, tx, ty, lim, span, cnt, pick;
    bit paused;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.cmd     <= CMD_STEP;
    cmd_ch.start_x <= '0;
    cmd_ch.start_y <= '0;
    cmd_ch.end_x   <= '0;
    cmd_ch.end_y   <= '0;
    cmd_ch.colour  <= '0;

    plan = '{
      // step while idle after reset
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b1, 1'b1, '0},
      // zero-length line: first step closes it
      '{CMD_START, 11'sd3, 11'sd4, 11'sd3, 11'sd4, 4'd9, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b1, 1'b0,
        '{12'sd3, 12'sd4, 4'd9, 1'b1}},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b1, 1'b1, '0},
      // full-range diagonal, abandoned by the next start
      '{CMD_START, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023, 4'd15, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b1, 1'b0,
        '{-12'sd1024, -12'sd1024, 4'd15, 1'b0}},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      // equal spans, negative x direction
      '{CMD_START, 11'sd1023, -11'sd1024, -11'sd1024, 11'sd1023, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b1, 1'b0,
        '{12'sd1023, -12'sd1024, 4'd0, 1'b0}},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      // steep line run to completion
      '{CMD_START, 11'sd0, 11'sd0, 11'sd1, 11'sd5, 4'd5, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      // negative minor: accumulator truncates toward zero, not down
      '{CMD_START, 11'sd0, 11'sd0, -11'sd3, -11'sd2, 4'd10, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0},
      '{CMD_STEP,  11'sd0, 11'sd0, 11'sd0, 11'sd0, 4'd0, 1'b0, 1'b0, '0}
    };

    ln_org_x = '0; ln_org_y = '0; ln_fin_x = '0; ln_fin_y = '0; ln_colour = '0;
    ln_steep = 1'b0; ln_neg = 1'b0; ln_busy = 1'b0;
    ln_idx = 0; ln_span = 0; ln_accum = 0; ln_incr = 0;
    paused = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_item(plan[i].op, plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey, plan[i].col,
                plan[i].typed, plan[i].none, plan[i].pix);
    wait_drained();

    while (items_sent < $size(plan) + RANDOM_ITEMS) begin
      if (!paused && items_sent > $size(plan) + RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: any command with any payload
        send_item(logic'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), 4'($urandom));
      end else begin
        sx = $urandom_range(0, 2047) - 1024;
        sy = $urandom_range(0, 2047) - 1024;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          tx = $urandom_range(0, 2047) - 1024;
          ty = $urandom_range(0, 2047) - 1024;
        end else begin
          lim = (pick < 18) ? 64 : 10;
          dx = $urandom_range(0, 2 * lim) - lim;
          dy = $urandom_range(0, 2 * lim) - lim;
          tx = sx + dx;
          ty = sy + dy;
          if (tx > 1023 || tx < -1024) tx = sx - dx;
          if (ty > 1023 || ty < -1024) ty = sy - dy;
        end
        dx = (tx > sx) ? tx - sx : sx - tx;
        dy = (ty > sy) ? ty - sy : sy - ty;
        span = (dy > dx) ? dy : dx;
        if (pick < 4) begin
          cnt = $urandom_range(1, 40);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 75) cnt = span + 1;
          else if (pick < 88) cnt = span + 1 + $urandom_range(1, 3);
          else cnt = $urandom_range(0, span);
        end
        send_item(CMD_START, coord_t'(sx), coord_t'(sy), coord_t'(tx), coord_t'(ty),
                  4'($urandom));
        repeat (cnt)
          send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), 4'($urandom));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d line starts); checked %0d pixels over %0d closed lines.",
             items_sent, starts_sent, pixels_checked, lines_closed);
    $display("Mismatches: %0d, pixels still owed: %0d", mismatches, pending_pixels.size());
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("** fixed_point_line_rasterizer: PASSED **");
    else
      $display("** fixed_point_line_rasterizer: FAILED **");
    $finish;
  end

endmodule
